FILE: sv/bpa_pkg.sv
// shared types, codes and constants of the buddy page allocator
`default_nettype none
package bpa_pkg;

   localparam int PAGE_W    = 12;
   localparam int ORDER_W   = 4;
   localparam int STATUS_W  = 2;
   localparam int ORD_W     = 5;   // internal order, holds top order plus one
   localparam int WBIT_W    = 4;   // log2 of the free map word width
   localparam int WORD_BITS = 1 << WBIT_W;

   localparam int PAGE_BITS_DEFAULT   = 12;
   localparam int ORDER_LIMIT_DEFAULT = 10;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_BLOCK   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_ORDER  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd3;

   typedef struct packed {
      logic               mode;
      logic [ORDER_W-1:0] order;
      logic [PAGE_W-1:0]  page_number;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   base_page;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic rd_scan;
      logic rd_pair;
      logic wr_en;
      logic wr_self_en;
      logic wr_self_val;
      logic wr_bud_en;
      logic wr_bud_val;
      logic found;
      logic scan_next;
      logic scan_order_next;
      logic split_down;
      logic merge_up;
      logic clr_wr;
   } cmd_type;

   typedef struct packed {
      logic              bad_order;
      logic              bad_align;
      logic              mode;
      logic              scan_hit;
      logic              scan_last;
      logic              o_at_req;
      logic              o_at_top;
      logic              buddy_free;
      logic              clr_done;
      logic [PAGE_W-1:0] base_page;
   } stat_type;

endpackage
`default_nettype wire

FILE: sv/buddy_page_allocator_top.sv
// top level of the buddy page allocator
//
// requests come in on the req_ channel: mode 0 allocates a block of 2^order
// pages, mode 1 frees the block at page_number. each request gives exactly
// one rsp_ transfer carrying a status code and, for a good allocate, the
// base page of the block.
// one request is in work at a time. a bad order or a misaligned free
// is answered without touching the free map. a free sets its bit and
// merges with a free buddy level by level, up to the top order at most.
// an allocate scans the free map a word at a time (16 slots a word, one
// read port) from the requested order upward, then splits down to it;
// with nothing free it answers with no block.
// after reset the free map, 2^(PAGE_BITS-3) words (512 at the default
// size), is cleared one word a cycle with req_stall high; nothing is free
// until software frees ranges.
// the result sits in an output register: a stalled response holds, and
// the next request may be taken meanwhile; its result waits for the slot.
`default_nettype none
module buddy_page_allocator_top #(
   parameter int PAGE_BITS   = bpa_pkg::PAGE_BITS_DEFAULT,
   parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEFAULT
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output bpa_pkg::rsp_type rsp_data
);
   import bpa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencer: one state per memory access
   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // free map and index arithmetic
   bpa_datapath #(
      .PAGE_BITS   (PAGE_BITS),
      .ORDER_LIMIT (ORDER_LIMIT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat)
   );

`ifndef SYNTH
   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_stall)
      else $error("request taken during free map clear");

   // a failed request never carries a page
   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.base_page == '0)
      else $error("failed request returned a page");

   // clearing and a map update never share the write port
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clr_wr && cmd.wr_en))
      else $error("free map write conflict");

   // loading a request only happens while requests are taken
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !req_stall && req_valid)
      else $error("request loaded without transfer");
`endif

endmodule
`default_nettype wire

FILE: sv/bpa_datapath.sv
// free map memory, order and index registers, word scan and bit update logic
`default_nettype none
module bpa_datapath #(
   parameter int PAGE_BITS   = bpa_pkg::PAGE_BITS_DEFAULT,
   parameter int ORDER_LIMIT = bpa_pkg::ORDER_LIMIT_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  bpa_pkg::req_type  req_data,
   input  bpa_pkg::cmd_type  cmd,
   output bpa_pkg::stat_type stat
);
   import bpa_pkg::*;

   localparam int TOP    = (ORDER_LIMIT < PAGE_BITS) ? ORDER_LIMIT : PAGE_BITS;
   localparam int SLOT_W = PAGE_BITS + 1;
   localparam int IDX_W  = PAGE_BITS;
   localparam int WA_W   = SLOT_W - WBIT_W;
   localparam int NWORDS = 1 << WA_W;

   logic [WORD_BITS-1:0] mem [NWORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [WA_W-1:0]      addr_ff, addr_in;
   logic [WA_W-1:0]      w_ff, w_in;
   logic [WA_W-1:0]      clr_ptr_ff, clr_ptr_in;
   logic [ORD_W-1:0]     o_ff, o_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 mode_ff;
   logic [ORDER_W-1:0]   order_ff;
   logic [PAGE_W-1:0]    page_ff;

   // first map slot of an order
   function automatic logic [SLOT_W:0] base_of(input logic [ORD_W-1:0] o);
      logic [SLOT_W:0] map_size;
      map_size = (SLOT_W+1)'(1) << SLOT_W;
      return map_size - (map_size >> o);
   endfunction

   logic [SLOT_W:0]      base_cur, base_nxt, last_full;
   logic [SLOT_W-1:0]    slot_self, last_slot, found_slot;
   logic [WA_W-1:0]      self_word, base_word, last_word, nxt_word;
   logic [WBIT_W-1:0]    self_bit, bud_bit, lo_bit, hi_bit, pos;
   logic [WORD_BITS-1:0] hit_bits, wdata;
   logic                 hit;
   logic [WA_W-1:0]      rd_addr;
   logic                 rd_en;

   always_comb begin
      base_cur   = base_of(o_ff);
      base_nxt   = base_of(o_ff + ORD_W'(1));
      last_full  = base_nxt - (SLOT_W+1)'(1);
      last_slot  = last_full[SLOT_W-1:0];
      slot_self  = SLOT_W'(base_cur + (SLOT_W+1)'(idx_ff));
      self_word  = slot_self[SLOT_W-1:WBIT_W];
      self_bit   = slot_self[WBIT_W-1:0];
      bud_bit    = {self_bit[WBIT_W-1:1], ~self_bit[0]};
      base_word  = base_cur[SLOT_W-1:WBIT_W];
      last_word  = last_slot[SLOT_W-1:WBIT_W];
      nxt_word   = base_nxt[SLOT_W-1:WBIT_W];
      lo_bit     = (w_ff == base_word) ? base_cur[WBIT_W-1:0] : '0;
      hi_bit     = (w_ff == last_word) ? last_slot[WBIT_W-1:0] : '1;
      for (int b = 0; b < WORD_BITS; b++) begin
         hit_bits[b] = rdata_ff[b] && (WBIT_W'(b) >= lo_bit) && (WBIT_W'(b) <= hi_bit);
      end
      // lowest set bit
      hit = 1'b0;
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (hit_bits[b]) begin
            hit = 1'b1;
            pos = WBIT_W'(b);
         end
      end
      found_slot = {w_ff, pos};
      wdata = rdata_ff;
      if (cmd.wr_self_en) wdata[self_bit] = cmd.wr_self_val;
      if (cmd.wr_bud_en)  wdata[bud_bit]  = cmd.wr_bud_val;
      rd_en   = cmd.rd_scan || cmd.rd_pair;
      rd_addr = cmd.rd_scan ? w_ff : self_word;
   end

   always_comb begin
      o_in       = o_ff;
      idx_in     = idx_ff;
      w_in       = w_ff;
      addr_in    = addr_ff;
      clr_ptr_in = clr_ptr_ff;
      if (cmd.load) begin
         o_in   = ORD_W'(req_data.order);
         idx_in = IDX_W'(req_data.page_number >> req_data.order);
         w_in   = WA_W'(base_of(ORD_W'(req_data.order)) >> WBIT_W);
      end
      if (cmd.found)           idx_in = IDX_W'(SLOT_W'(found_slot - base_cur[SLOT_W-1:0]));
      if (cmd.scan_next)       w_in   = w_ff + WA_W'(1);
      if (cmd.scan_order_next) begin
         o_in = o_ff + ORD_W'(1);
         w_in = nxt_word;
      end
      if (cmd.split_down) begin
         o_in   = o_ff - ORD_W'(1);
         idx_in = {idx_ff[IDX_W-2:0], 1'b0};
      end
      if (cmd.merge_up) begin
         o_in   = o_ff + ORD_W'(1);
         idx_in = idx_ff >> 1;
      end
      if (cmd.rd_pair) addr_in    = self_word;
      if (cmd.clr_wr)  clr_ptr_in = clr_ptr_ff + WA_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff <= '0;
      end else begin
         clr_ptr_ff <= clr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      o_ff    <= o_in;
      idx_ff  <= idx_in;
      w_ff    <= w_in;
      addr_ff <= addr_in;
      if (cmd.load) begin
         mode_ff  <= req_data.mode;
         order_ff <= req_data.order;
         page_ff  <= req_data.page_number;
      end
   end

   // free map storage
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_ptr_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[addr_ff] <= wdata;
      end
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_comb begin
      stat.bad_order  = ORD_W'(order_ff) > ORD_W'(TOP);
      stat.bad_align  = ((32'(page_ff) >> PAGE_BITS) != 32'd0) ||
                        ((page_ff & ~({PAGE_W{1'b1}} << order_ff)) != '0);
      stat.mode       = mode_ff;
      stat.scan_hit   = hit;
      stat.scan_last  = (w_ff == last_word);
      stat.o_at_req   = (o_ff == ORD_W'(order_ff));
      stat.o_at_top   = (o_ff == ORD_W'(TOP));
      stat.buddy_free = rdata_ff[bud_bit];
      stat.clr_done   = &clr_ptr_ff;
      stat.base_page  = PAGE_W'(32'(idx_ff) << o_ff);
   end

endmodule
`default_nettype wire

FILE: sv/bpa_ctrl.sv
// request sequencer and response register of the buddy page allocator
`default_nettype none
module bpa_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output bpa_pkg::rsp_type  rsp_data,
   output bpa_pkg::cmd_type  cmd,
   input  bpa_pkg::stat_type stat
);
   import bpa_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_DECIDE    = 4'd2;
   localparam logic [3:0] S_SCAN_RD   = 4'd3;
   localparam logic [3:0] S_SCAN_CHK  = 4'd4;
   localparam logic [3:0] S_A_CLR_RD  = 4'd5;
   localparam logic [3:0] S_A_CLR_WR  = 4'd6;
   localparam logic [3:0] S_A_PAIR_RD = 4'd7;
   localparam logic [3:0] S_A_PAIR_WR = 4'd8;
   localparam logic [3:0] S_F_SET_RD  = 4'd9;
   localparam logic [3:0] S_F_SET_WR  = 4'd10;
   localparam logic [3:0] S_F_BUD_RD  = 4'd11;
   localparam logic [3:0] S_F_BUD_CHK = 4'd12;
   localparam logic [3:0] S_RESP      = 4'd13;

   logic [3:0]          state_ff, state_in;
   logic [STATUS_W-1:0] code_ff, code_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd          = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.bad_order) begin
               code_in  = ST_BAD_ORDER;
               state_in = S_RESP;
            end else if (stat.mode) begin
               if (stat.bad_align) begin
                  code_in  = ST_MISALIGNED;
                  state_in = S_RESP;
               end else begin
                  cmd.rd_pair = 1'b1;
                  state_in    = S_F_SET_WR;
               end
            end else begin
               cmd.rd_scan = 1'b1;
               state_in    = S_SCAN_CHK;
            end
         end
         S_SCAN_RD: begin
            cmd.rd_scan = 1'b1;
            state_in    = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (stat.scan_hit) begin
               cmd.found = 1'b1;
               state_in  = S_A_CLR_RD;
            end else if (stat.scan_last) begin
               if (stat.o_at_top) begin
                  code_in  = ST_NO_BLOCK;
                  state_in = S_RESP;
               end else begin
                  cmd.scan_order_next = 1'b1;
                  state_in            = S_SCAN_RD;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_A_CLR_RD: begin
            cmd.rd_pair = 1'b1;
            state_in    = S_A_CLR_WR;
         end
         S_A_CLR_WR, S_A_PAIR_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_self_en  = 1'b1;
            cmd.wr_self_val = 1'b0;
            // split levels hand the right half back
            cmd.wr_bud_en   = (state_ff == S_A_PAIR_WR);
            cmd.wr_bud_val  = 1'b1;
            if (stat.o_at_req) begin
               code_in  = ST_OK;
               state_in = S_RESP;
            end else begin
               cmd.split_down = 1'b1;
               state_in       = S_A_PAIR_RD;
            end
         end
         S_A_PAIR_RD: begin
            cmd.rd_pair = 1'b1;
            state_in    = S_A_PAIR_WR;
         end
         S_F_SET_RD: begin
            cmd.rd_pair = 1'b1;
            state_in    = S_F_SET_WR;
         end
         S_F_SET_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_self_en  = 1'b1;
            cmd.wr_self_val = 1'b1;
            if (stat.o_at_top) begin
               code_in  = ST_OK;
               state_in = S_RESP;
            end else begin
               state_in = S_F_BUD_RD;
            end
         end
         S_F_BUD_RD: begin
            cmd.rd_pair = 1'b1;
            state_in    = S_F_BUD_CHK;
         end
         S_F_BUD_CHK: begin
            if (stat.buddy_free) begin
               // both halves leave this order, the parent is set next
               cmd.wr_en       = 1'b1;
               cmd.wr_self_en  = 1'b1;
               cmd.wr_self_val = 1'b0;
               cmd.wr_bud_en   = 1'b1;
               cmd.wr_bud_val  = 1'b0;
               cmd.merge_up    = 1'b1;
               state_in        = S_F_SET_RD;
            end else begin
               code_in  = ST_OK;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = code_ff;
               rsp_in.base_page = (code_ff == ST_OK && !stat.mode) ? stat.base_page : '0;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
